// ----- rtl/core/ebs_pkg.sv -----
`timescale 1ns / 1ps

package ebs_pkg;

  localparam int MAX_LINE_LEN_DEF = 64;
  localparam int MAX_LINES_DEF    = 64;

  localparam int CFG_W     = 7;
  localparam int REG_IDX_W = 1;
  localparam int SAMPLE_W  = 16;
  localparam int IDX_W     = 6;

  // window of column sums, one per cell
  localparam int WIN   = 3;
  localparam int COL_W = 18;
  localparam int SUM_W = 20;
  localparam int CNT_W = 4;

  localparam logic [CFG_W-1:0] GRID_LINES_RST  = 7'd24;
  localparam logic [CFG_W-1:0] LINE_LENGTH_RST = 7'd24;

  localparam logic [REG_IDX_W-1:0] REG_GRID_LINES  = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_LINE_LENGTH = 1'b1;

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_FLUSH  = 1'b1;

  typedef logic [COL_W-1:0] col_t;
  typedef logic [SUM_W-1:0] sum_t;

  typedef struct packed {
    logic shift;
    logic clr;
  } shift_t;

endpackage

// ----- rtl/core/ebs_in_if.sv -----
`timescale 1ns / 1ps

interface ebs_in_if;
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic [ebs_pkg::SAMPLE_W-1:0]  sample;

  modport source (output valid, output req_type, output sample, input ready);
  modport sink   (input valid, input req_type, input sample, output ready);
endinterface

// ----- rtl/core/ebs_out_if.sv -----
`timescale 1ns / 1ps

interface ebs_out_if;
  logic                          valid;
  logic                          ready;
  logic [ebs_pkg::SAMPLE_W-1:0]  smoothed;
  logic [ebs_pkg::IDX_W-1:0]     line_index;
  logic [ebs_pkg::IDX_W-1:0]     sample_index;
  logic                          frame_last;

  modport source (output valid, output smoothed, output line_index, output sample_index,
                  output frame_last, input ready);
  modport sink   (input valid, input smoothed, input line_index, input sample_index,
                  input frame_last, output ready);
endinterface

// ----- rtl/core/ebs_col_cell.sv -----
`timescale 1ns / 1ps

module ebs_col_cell (
  input  logic            clk,
  input  logic            rst,
  input  ebs_pkg::shift_t ctl,
  input  ebs_pkg::col_t   in_sum,
  input  logic            in_valid,
  output ebs_pkg::col_t   sum,
  output logic            valid
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.shift) begin
      valid <= in_valid & ~ctl.clr;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      sum <= in_sum;
    end
  end

endmodule

// ----- rtl/core/ebs_line_store.sv -----
`timescale 1ns / 1ps

module ebs_line_store #(
  parameter int DEPTH = 2 * ebs_pkg::MAX_LINE_LEN_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [AW-1:0]                waddr,
  input  logic [ebs_pkg::SAMPLE_W-1:0] wdata,
  input  logic                         re,
  input  logic [AW-1:0]                ra,
  input  logic [AW-1:0]                rb,
  output logic [ebs_pkg::SAMPLE_W-1:0] qa,
  output logic [ebs_pkg::SAMPLE_W-1:0] qb
);

  logic [ebs_pkg::SAMPLE_W-1:0] mem [DEPTH];

  // read returns the old word on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      qa <= mem[ra];
      qb <= mem[rb];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

// ----- rtl/core/ebs_mean_div.sv -----
`timescale 1ns / 1ps

module ebs_mean_div (
  input  logic                         clk,
  input  logic                         start,
  input  ebs_pkg::sum_t                sum,
  input  logic [ebs_pkg::CNT_W-1:0]    cnt,
  output logic [ebs_pkg::SAMPLE_W-1:0] mean
);

  localparam int RECIP_W  = 25;
  localparam int RECIP_SH = 24;
  localparam int PROD_W   = ebs_pkg::SUM_W + RECIP_W;

  // ceil(2^24 / c); exact floor for sums below 2^20
  function automatic logic [RECIP_W-1:0] recip(input logic [ebs_pkg::CNT_W-1:0] c);
    logic [RECIP_W-1:0] r;
    unique case (c)
      4'd1:    r = 25'd16777216;
      4'd2:    r = 25'd8388608;
      4'd3:    r = 25'd5592406;
      4'd4:    r = 25'd4194304;
      4'd6:    r = 25'd2796203;
      4'd9:    r = 25'd1864136;
      default: r = '0;
    endcase
    return r;
  endfunction

  ebs_pkg::sum_t      sum_q;
  logic [RECIP_W-1:0] recip_q;
  logic [PROD_W-1:0]  prod;

  always_ff @(posedge clk) begin
    if (start) begin
      sum_q   <= sum;
      recip_q <= recip(cnt);
    end
    prod <= sum_q * recip_q;
  end

  assign mean = prod[RECIP_SH +: ebs_pkg::SAMPLE_W];

endmodule

// ----- rtl/core/edge_normalized_box_smoother.sv -----
// 3x3 mean filter over a raster grid, edges normalised by the number of in-bounds neighbours.
// Results trail the input by one line; the last line is drained by flush words, one result
// each, and the final result of the frame carries frame_last. Grid size comes from the
// grid_lines and line_length registers (0 acts as 1, oversize values clamp to the maximum);
// a register write restarts the frame. A sample word yields up to two results and a flush
// word one; a new word is taken only once the last one's results are in the output register.
// The pace is set by the one shared column fetch from the two-line store, which feeds a row of
// three column-sum cells, and by the reciprocal multiplier that every result passes through in
// turn. A finished result waits in the output register while the next word is taken.
`timescale 1ns / 1ps

module edge_normalized_box_smoother #(
  parameter int MAX_LINE_LEN = ebs_pkg::MAX_LINE_LEN_DEF,
  parameter int MAX_LINES    = ebs_pkg::MAX_LINES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [ebs_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [ebs_pkg::CFG_W-1:0]     cfg_data,
  ebs_in_if.sink                        req,
  ebs_out_if.source                     res
);

  localparam int SW    = $clog2(MAX_LINE_LEN);
  localparam int LW    = $clog2(MAX_LINES);
  localparam int NW    = $clog2(MAX_LINE_LEN + 1);
  localparam int GW    = $clog2(MAX_LINES + 1);
  localparam int NCW   = (NW > ebs_pkg::CFG_W) ? NW : ebs_pkg::CFG_W;
  localparam int GCW   = (GW > ebs_pkg::CFG_W) ? GW : ebs_pkg::CFG_W;
  localparam int DEPTH = 2 * MAX_LINE_LEN;
  localparam int AW    = $clog2(DEPTH);
  localparam int SXW   = (SW > ebs_pkg::IDX_W) ? SW : ebs_pkg::IDX_W;
  localparam int LXW   = (LW > ebs_pkg::IDX_W) ? LW : ebs_pkg::IDX_W;
  localparam int WIN   = ebs_pkg::WIN;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_FETCH = 5'b00010,
    ST_SUM   = 5'b00100,
    ST_MUL   = 5'b01000,
    ST_OUT   = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [ebs_pkg::CFG_W-1:0] grid_lines, line_length;
  logic [GCW-1:0] g_raw;
  logic [NCW-1:0] n_raw;
  logic [GW-1:0]  g_eff;
  logic [NW-1:0]  n_eff;

  logic [LW-1:0] in_line_pos;
  logic [SW-1:0] in_sample_pos;
  logic [SW-1:0] drain_pos;
  logic          draining;

  logic take_sample, take_flush;
  logic s_wrap, l_wrap, d_last, d_next_ok;

  // per-word working registers
  logic                         w_flush;
  logic [ebs_pkg::SAMPLE_W-1:0] w_smp;
  logic                         w_pa, w_ea, w_eb;
  logic                         w_clr, w_colvalid, w_second, w_last;
  logic [1:0]                   w_rows;
  logic [LW-1:0]                w_oline;
  logic [SW-1:0]                w_ocol;
  logic                         res_a, res_b;

  logic [SW-1:0]                fetch_col;
  logic                         fetch_pa, fetch_re;
  logic [AW-1:0]                ra, rb;
  logic [ebs_pkg::SAMPLE_W-1:0] qa, qb;

  ebs_pkg::col_t      colsum;
  ebs_pkg::col_t      cell_sum [WIN];
  logic [WIN-1:0]     cell_valid;
  logic               shift_en;

  ebs_pkg::sum_t              win_sum;
  logic [1:0]                 win_cols;
  logic [ebs_pkg::CNT_W-1:0]  cnt;
  logic [ebs_pkg::SAMPLE_W-1:0] mean;

  logic [LW-1:0]  o_line;
  logic [SW-1:0]  o_col;
  logic           o_last;
  logic [LXW-1:0] line_x;
  logic [SXW-1:0] col_x;
  logic           out_load;

  // register clamping
  assign g_raw = GCW'(grid_lines);
  assign n_raw = NCW'(line_length);

  always_comb begin
    if (g_raw == '0) begin
      g_eff = GW'(1);
    end else if (g_raw > GCW'(MAX_LINES)) begin
      g_eff = GW'(MAX_LINES);
    end else begin
      g_eff = GW'(g_raw);
    end
    if (n_raw == '0) begin
      n_eff = NW'(1);
    end else if (n_raw > NCW'(MAX_LINE_LEN)) begin
      n_eff = NW'(MAX_LINE_LEN);
    end else begin
      n_eff = NW'(n_raw);
    end
  end

  assign req.ready   = (state == ST_IDLE);
  assign take_sample = req.valid && req.ready && (req.req_type == ebs_pkg::REQ_SAMPLE)
                       && !draining;
  assign take_flush  = req.valid && req.ready && (req.req_type == ebs_pkg::REQ_FLUSH)
                       && draining;

  assign s_wrap    = (NW'(in_sample_pos) + NW'(1)) >= n_eff;
  assign l_wrap    = (GW'(in_line_pos) + GW'(1)) >= g_eff;
  assign d_last    = (NW'(drain_pos) + NW'(1)) >= n_eff;
  assign d_next_ok = !d_last;

  // column fetch: two rows of one column per cycle
  always_comb begin
    fetch_col = '0;
    fetch_pa  = 1'b0;
    fetch_re  = 1'b0;
    if (take_sample) begin
      fetch_col = in_sample_pos;
      fetch_pa  = in_line_pos[0];
      fetch_re  = 1'b1;
    end else if (take_flush) begin
      fetch_col = ((drain_pos == '0) || !d_next_ok) ? '0 : drain_pos + 1'b1;
      fetch_pa  = ~g_eff[0];
      fetch_re  = 1'b1;
    end else if ((state == ST_FETCH) && w_second) begin
      fetch_col = SW'(1);
      fetch_pa  = w_pa;
      fetch_re  = (n_eff > NW'(1));
    end
  end

  assign ra = fetch_pa ? (AW'(MAX_LINE_LEN) + AW'(fetch_col)) : AW'(fetch_col);
  assign rb = fetch_pa ? AW'(fetch_col) : (AW'(MAX_LINE_LEN) + AW'(fetch_col));

  ebs_line_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (take_sample),
    .waddr (ra),
    .wdata (req.sample),
    .re    (fetch_re),
    .ra    (ra),
    .rb    (rb),
    .qa    (qa),
    .qb    (qb)
  );

  assign colsum = (w_ea ? ebs_pkg::COL_W'(qa) : '0) + (w_eb ? ebs_pkg::COL_W'(qb) : '0)
                  + ebs_pkg::COL_W'(w_smp);
  assign shift_en = (state == ST_FETCH);

  for (genvar i = 0; i < WIN; i++) begin : g_cell
    ebs_pkg::col_t   in_s;
    logic            in_v;
    ebs_pkg::shift_t ctl;
    if (i == 0) begin : g_head
      assign in_s = colsum;
      assign in_v = w_colvalid;
      assign ctl  = '{shift: shift_en, clr: 1'b0};
    end else begin : g_tail
      assign in_s = cell_sum[i-1];
      assign in_v = cell_valid[i-1];
      assign ctl  = '{shift: shift_en, clr: w_clr};
    end
    ebs_col_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .in_sum   (in_s),
      .in_valid (in_v),
      .sum      (cell_sum[i]),
      .valid    (cell_valid[i])
    );
  end

  // window sum; the trailing result of a line leaves out the oldest column
  always_comb begin
    win_sum  = '0;
    win_cols = '0;
    for (int i = 0; i < WIN; i++) begin
      if (cell_valid[i] && (res_a || (i < WIN - 1))) begin
        win_sum  = win_sum + ebs_pkg::SUM_W'(cell_sum[i]);
        win_cols = win_cols + 2'd1;
      end
    end
    cnt = ebs_pkg::CNT_W'(w_rows) * ebs_pkg::CNT_W'(win_cols);
  end

  ebs_mean_div u_div (
    .clk   (clk),
    .start (state == ST_SUM),
    .sum   (win_sum),
    .cnt   (cnt),
    .mean  (mean)
  );

  assign out_load = (state == ST_OUT) && (!res.valid || res.ready);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (take_sample || take_flush) state_next = ST_FETCH;
      ST_FETCH: if (!w_second) state_next = (res_a || res_b) ? ST_SUM : ST_IDLE;
      ST_SUM:   state_next = ST_MUL;
      ST_MUL:   state_next = ST_OUT;
      ST_OUT:   if (out_load) state_next = (res_a || res_b) ? ST_SUM : ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration and frame position
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_lines    <= ebs_pkg::GRID_LINES_RST;
      line_length   <= ebs_pkg::LINE_LENGTH_RST;
      in_line_pos   <= '0;
      in_sample_pos <= '0;
      drain_pos     <= '0;
      draining      <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == ebs_pkg::REG_GRID_LINES) begin
        grid_lines <= cfg_data;
      end
      if (cfg_index == ebs_pkg::REG_LINE_LENGTH) begin
        line_length <= cfg_data;
      end
      in_line_pos   <= '0;
      in_sample_pos <= '0;
      drain_pos     <= '0;
      draining      <= 1'b0;
    end else if (take_sample) begin
      if (s_wrap) begin
        in_sample_pos <= '0;
        if (l_wrap) begin
          in_line_pos <= '0;
          drain_pos   <= '0;
          draining    <= 1'b1;
        end else begin
          in_line_pos <= in_line_pos + 1'b1;
        end
      end else begin
        in_sample_pos <= in_sample_pos + 1'b1;
      end
    end else if (take_flush) begin
      if (d_last) begin
        in_line_pos   <= '0;
        in_sample_pos <= '0;
        drain_pos     <= '0;
        draining      <= 1'b0;
      end else begin
        drain_pos <= drain_pos + 1'b1;
      end
    end
  end

  // working registers of the current word
  always_ff @(posedge clk) begin
    if (rst) begin
      w_second <= 1'b0;
      res_a    <= 1'b0;
      res_b    <= 1'b0;
    end else if (take_sample) begin
      w_flush    <= 1'b0;
      w_smp      <= req.sample;
      w_pa       <= in_line_pos[0];
      w_ea       <= in_line_pos >= LW'(2);
      w_eb       <= in_line_pos != '0;
      w_clr      <= in_sample_pos == '0;
      w_colvalid <= 1'b1;
      w_second   <= 1'b0;
      w_rows     <= (in_line_pos >= LW'(2)) ? 2'd3 : 2'd2;
      w_oline    <= in_line_pos - 1'b1;
      w_ocol     <= in_sample_pos;
      w_last     <= 1'b0;
      res_a      <= (in_line_pos != '0) && (in_sample_pos != '0);
      res_b      <= (in_line_pos != '0) && s_wrap;
    end else if (take_flush) begin
      w_flush    <= 1'b1;
      w_smp      <= '0;
      w_pa       <= ~g_eff[0];
      w_ea       <= 1'b1;
      w_eb       <= g_eff >= GW'(2);
      w_clr      <= drain_pos == '0;
      w_colvalid <= (drain_pos == '0) || d_next_ok;
      w_second   <= drain_pos == '0;
      w_rows     <= (g_eff >= GW'(2)) ? 2'd2 : 2'd1;
      w_oline    <= LW'(g_eff - GW'(1));
      w_ocol     <= drain_pos;
      w_last     <= d_last;
      res_a      <= 1'b1;
      res_b      <= 1'b0;
    end else if ((state == ST_FETCH) && w_second) begin
      w_second   <= 1'b0;
      w_clr      <= 1'b0;
      w_colvalid <= n_eff > NW'(1);
    end else if (state == ST_SUM) begin
      if (res_a) begin
        res_a <= 1'b0;
      end else begin
        res_b <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SUM) begin
      o_line <= w_oline;
      if (res_a) begin
        o_col  <= w_flush ? w_ocol : w_ocol - 1'b1;
        o_last <= w_last;
      end else begin
        o_col  <= w_ocol;
        o_last <= 1'b0;
      end
    end
  end

  assign line_x = LXW'(o_line);
  assign col_x  = SXW'(o_col);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (out_load) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res.smoothed     <= mean;
      res.line_index   <= line_x[ebs_pkg::IDX_W-1:0];
      res.sample_index <= col_x[ebs_pkg::IDX_W-1:0];
      res.frame_last   <= o_last;
    end
  end

  a_last_flush_restarts: assert property (@(posedge clk) disable iff (rst)
    (take_flush && d_last) |=> (!draining && (in_line_pos == '0) && (drain_pos == '0)))
    else $error("frame not restarted after final flush");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SUM) |-> (cnt != '0))
    else $error("empty neighbourhood at mean stage");

  a_sample_fills_head: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_FETCH) && !w_flush) |=> cell_valid[0])
    else $error("sample column not latched in head cell");

endmodule

// ----- tb/edge_normalized_box_smoother_tb.sv -----
`timescale 1ns / 1ps

module edge_normalized_box_smoother_tb;

  localparam int LINE_CAP    = ebs_pkg::MAX_LINE_LEN_DEF;
  localparam int LINES_CAP   = ebs_pkg::MAX_LINES_DEF;
  localparam int WORD_GOAL   = 1700;
  localparam int SETTLE      = 12;
  localparam int SQUEEZE_LEN = 300;
  localparam int SQUEEZE_AT  = 150;
  localparam int DRAIN_LIMIT = 20000;

  typedef struct packed {
    logic [ebs_pkg::SAMPLE_W-1:0] mean;
    logic [ebs_pkg::IDX_W-1:0]    line;
    logic [ebs_pkg::IDX_W-1:0]    col;
    logic                         last;
  } window_mean_t;

  class mean_board;
    logic [ebs_pkg::CFG_W-1:0]    grid_reg;
    logic [ebs_pkg::CFG_W-1:0]    len_reg;
    logic [ebs_pkg::SAMPLE_W-1:0] lines [2*LINE_CAP];
    int unsigned                  in_line;
    int unsigned                  in_col;
    int unsigned                  drain_col;
    bit                           draining;
    int unsigned                  col_sum1;
    int unsigned                  col_sum2;
    window_mean_t                 due[$];
    int                           errors;

    function new();
      grid_reg = ebs_pkg::GRID_LINES_RST;
      len_reg  = ebs_pkg::LINE_LENGTH_RST;
      foreach (lines[i]) lines[i] = '0;
      errors = 0;
      restart();
    endfunction

    function void restart();
      in_line   = 0;
      in_col    = 0;
      drain_col = 0;
      draining  = 0;
      col_sum1  = 0;
      col_sum2  = 0;
    endfunction

    function int unsigned clamp(int unsigned v, int unsigned cap);
      if (v == 0) return 1;
      if (v > cap) return cap;
      return v;
    endfunction

    function int unsigned lines_eff();
      return clamp(grid_reg, LINES_CAP);
    endfunction

    function int unsigned len_eff();
      return clamp(len_reg, LINE_CAP);
    endfunction

    function int unsigned slot(int unsigned ln, int unsigned c);
      return (ln & 1) * LINE_CAP + (c % LINE_CAP);
    endfunction

    function void write_reg(logic [ebs_pkg::REG_IDX_W-1:0] idx,
                            logic [ebs_pkg::CFG_W-1:0] val);
      if (idx == ebs_pkg::REG_GRID_LINES) grid_reg = val;
      else len_reg = val;
      restart();
    endfunction

    function void push(int unsigned sum, int unsigned div, int unsigned ln,
                       int unsigned c, bit fl);
      window_mean_t w;
      w.mean = ebs_pkg::SAMPLE_W'(sum / div);
      w.line = ebs_pkg::IDX_W'(ln);
      w.col  = ebs_pkg::IDX_W'(c);
      w.last = fl;
      due.insert(due.size(), w);
    endfunction

    // predicts the results of one accepted word
    function void take_word(logic rq, logic [ebs_pkg::SAMPLE_W-1:0] smp);
      int unsigned g, n, ln, sp, top, mid, cnew, rows, sum, cols, lo, hi, d;
      g = lines_eff();
      n = len_eff();
      if (rq == ebs_pkg::REQ_SAMPLE) begin
        if (draining) return;
        ln   = in_line;
        sp   = in_col;
        top  = (ln >= 2) ? lines[slot(ln, sp)] : 0;
        mid  = (ln >= 1) ? lines[slot(ln - 1, sp)] : 0;
        cnew = top + mid + smp;
        lines[slot(ln, sp)] = smp;
        if (ln >= 1) begin
          rows = (ln >= 2) ? 3 : 2;
          if (sp >= 1) begin
            sum  = col_sum1 + cnew;
            cols = 2;
            if (sp >= 2) begin
              sum += col_sum2;
              cols = 3;
            end
            push(sum, rows * cols, ln - 1, sp - 1, 1'b0);
          end
          if (sp + 1 == n) begin
            sum  = cnew;
            cols = 1;
            if (sp >= 1) begin
              sum += col_sum1;
              cols = 2;
            end
            push(sum, rows * cols, ln - 1, sp, 1'b0);
          end
        end
        col_sum2 = col_sum1;
        col_sum1 = cnew;
        sp++;
        if (sp >= n) begin
          sp = 0;
          ln++;
          if (ln >= g) begin
            draining  = 1;
            drain_col = 0;
          end
        end
        in_col  = sp;
        in_line = ln;
      end else begin
        if (!draining) return;
        d    = drain_col;
        rows = (g >= 2) ? 2 : 1;
        sum  = 0;
        cols = 0;
        lo   = (d >= 1) ? d - 1 : 0;
        hi   = (d + 1 < n) ? d + 1 : n - 1;
        for (int unsigned c = lo; c <= hi; c++) begin
          sum += lines[slot(g - 1, c)];
          if (g >= 2) sum += lines[slot(g - 2, c)];
          cols++;
        end
        push(sum, rows * cols, g - 1, d, d + 1 >= n);
        d++;
        if (d >= n) restart();
        else drain_col = d;
      end
    endfunction

    task report(string msg);
      $display("ERROR @%0t: %s", $time, msg);
      errors++;
    endtask

    task match_result(logic [ebs_pkg::SAMPLE_W-1:0] m, logic [ebs_pkg::IDX_W-1:0] ln,
                      logic [ebs_pkg::IDX_W-1:0] c, logic fl);
      window_mean_t w;
      if (due.size() == 0) begin
        report($sformatf("unexpected result %h at %0d,%0d", m, ln, c));
        return;
      end
      w = due.pop_front();
      if (m !== w.mean)
        report($sformatf("smoothed %h, want %h at %0d,%0d", m, w.mean, w.line, w.col));
      if (ln !== w.line) report($sformatf("line_index %0d, want %0d", ln, w.line));
      if (c !== w.col) report($sformatf("sample_index %0d, want %0d", c, w.col));
      if (fl !== w.last)
        report($sformatf("frame_last %b, want %b at %0d,%0d", fl, w.last, w.line, w.col));
    endtask

    task close();
      if (due.size() != 0) report($sformatf("%0d results never arrived", due.size()));
    endtask
  endclass

  logic                          clk;
  logic                          rst;
  logic                          cfg_we;
  logic [ebs_pkg::REG_IDX_W-1:0] cfg_index;
  logic [ebs_pkg::CFG_W-1:0]     cfg_data;

  ebs_in_if  req_if ();
  ebs_out_if res_if ();

  edge_normalized_box_smoother dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_if),
    .res       (res_if)
  );

  mean_board sb;
  bit        quiet;
  bit        flood;
  int        results_seen;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  initial begin
    #15_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready) begin
      sb.match_result(res_if.smoothed, res_if.line_index, res_if.sample_index,
                      res_if.frame_last);
      results_seen++;
    end
  end

  // output side back-pressure, one long hold-off once the stream is going
  initial begin
    int  run_left;
    int  hold_left;
    bit  run_ready;
    bit  squeezed;
    run_left     = 0;
    hold_left    = 0;
    run_ready    = 1'b0;
    squeezed     = 1'b0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!squeezed && results_seen >= SQUEEZE_AT) begin
        squeezed  = 1'b1;
        hold_left = SQUEEZE_LEN;
        flood     = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready = 1'b0;
        if (hold_left == 0) flood = 1'b0;
      end else if (quiet) begin
        res_if.ready = 1'b1;
      end else begin
        if (run_left == 0) begin
          if ($urandom_range(0, 99) < 60) begin
            run_ready = 1'b1;
            run_left  = $urandom_range(1, 20);
          end else begin
            run_ready = 1'b0;
            run_left  = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                    : $urandom_range(1, 3);
          end
        end
        run_left--;
        res_if.ready = run_ready;
      end
    end
  end

  task automatic send_word(input logic rq, input logic [ebs_pkg::SAMPLE_W-1:0] smp);
    req_if.valid    = 1'b1;
    req_if.req_type = rq;
    req_if.sample   = smp;
    do @(posedge clk); while (!req_if.ready);
    sb.take_word(rq, smp);
    @(negedge clk);
  endtask

  task automatic pause();
    int g;
    if (quiet || flood) g = 0;
    else begin
      g = $urandom_range(0, 99);
      if (g < 50) g = 0;
      else if (g < 90) g = $urandom_range(1, 3);
      else g = $urandom_range(8, 30);
    end
    if (g > 0) begin
      req_if.valid = 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  task automatic write_reg(input logic [ebs_pkg::REG_IDX_W-1:0] idx,
                           input logic [ebs_pkg::CFG_W-1:0] val);
    req_if.valid = 1'b0;
    while (sb.due.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.write_reg(idx, val);
  endtask

  task automatic set_grid(input int g, input int n);
    if ($urandom_range(0, 1)) begin
      write_reg(ebs_pkg::REG_GRID_LINES, ebs_pkg::CFG_W'(g));
      write_reg(ebs_pkg::REG_LINE_LENGTH, ebs_pkg::CFG_W'(n));
    end else begin
      write_reg(ebs_pkg::REG_LINE_LENGTH, ebs_pkg::CFG_W'(n));
      write_reg(ebs_pkg::REG_GRID_LINES, ebs_pkg::CFG_W'(g));
    end
  endtask

  function automatic logic [ebs_pkg::SAMPLE_W-1:0] rand_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '1;
    if (r < 20) return '0;
    return ebs_pkg::SAMPLE_W'($urandom);
  endfunction

  initial begin
    int g, n, ge, ne, frames, total, cut, words;
    bit broken, stop;
    sb              = new();
    results_seen    = 0;
    quiet           = 1'b0;
    flood           = 1'b0;
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    req_if.valid    = 1'b0;
    req_if.req_type = ebs_pkg::REQ_SAMPLE;
    req_if.sample   = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // flush with nothing to drain
    send_word(ebs_pkg::REQ_FLUSH, 16'h1234);
    pause();
    set_grid(2, 3);
    send_word(ebs_pkg::REQ_SAMPLE, 16'hFFFF);
    send_word(ebs_pkg::REQ_SAMPLE, 16'h0000);
    send_word(ebs_pkg::REQ_SAMPLE, 16'hFFFF);
    pause();
    send_word(ebs_pkg::REQ_SAMPLE, 16'h0000);
    send_word(ebs_pkg::REQ_SAMPLE, 16'hFFFF);
    send_word(ebs_pkg::REQ_SAMPLE, 16'hFFFF);
    // sample while draining
    send_word(ebs_pkg::REQ_SAMPLE, 16'h5A5A);
    repeat (3) send_word(ebs_pkg::REQ_FLUSH, 16'h0000);
    set_grid(1, 1);
    send_word(ebs_pkg::REQ_SAMPLE, 16'hFFFF);
    send_word(ebs_pkg::REQ_FLUSH, 16'hFFFF);
    // zero registers act as one
    set_grid(0, 0);
    send_word(ebs_pkg::REQ_SAMPLE, 16'h8001);
    send_word(ebs_pkg::REQ_FLUSH, 16'h0000);
    set_grid(3, 2);
    repeat (6) send_word(ebs_pkg::REQ_SAMPLE, 16'hFFFF);
    repeat (2) send_word(ebs_pkg::REQ_FLUSH, 16'h0000);

    words = 0;
    while (words < WORD_GOAL) begin
      cut = $urandom_range(0, 99);
      if (cut < 70) begin
        g = $urandom_range(1, 8);
        n = $urandom_range(1, 8);
      end else if (cut < 80) begin
        g = $urandom_range(0, 1) ? LINES_CAP : $urandom_range(LINES_CAP + 1, 127);
        n = $urandom_range(1, 3);
      end else if (cut < 90) begin
        g = $urandom_range(1, 3);
        n = $urandom_range(0, 1) ? LINE_CAP : $urandom_range(LINE_CAP + 1, 127);
      end else begin
        g = $urandom_range(0, 2);
        n = $urandom_range(0, 2);
      end
      set_grid(g, n);
      quiet  = ($urandom_range(0, 4) == 0);
      ge     = sb.lines_eff();
      ne     = sb.len_eff();
      frames = $urandom_range(1, 3);
      stop   = 1'b0;
      for (int f = 0; f < frames && !stop; f++) begin
        total  = ge * ne + ne;
        broken = ($urandom_range(0, 99) < 8);
        cut    = $urandom_range(0, total - 1);
        for (int i = 0; i < total && !stop; i++) begin
          if (broken && i == cut) begin
            stop = 1'b1;
          end else if (i < ge * ne) begin
            if ($urandom_range(0, 99) < 3) begin
              send_word(ebs_pkg::REQ_FLUSH, ebs_pkg::SAMPLE_W'($urandom));
              pause();
            end
            send_word(ebs_pkg::REQ_SAMPLE, rand_sample());
            pause();
            words++;
            if (i == ge * ne - 1 && $urandom_range(0, 99) < 30) begin
              send_word(ebs_pkg::REQ_SAMPLE, rand_sample());
              pause();
            end
          end else begin
            send_word(ebs_pkg::REQ_FLUSH, ebs_pkg::SAMPLE_W'($urandom));
            pause();
            words++;
          end
        end
      end
    end

    req_if.valid = 1'b0;
    for (int i = 0; i < DRAIN_LIMIT && sb.due.size() != 0; i++) @(posedge clk);
    repeat (40) @(posedge clk);
    sb.close();
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
